// File: rtl/ostt_pkg.sv
// Shared constants, codes and types for the one-shot timer table.
`timescale 1ns / 1ps
`default_nettype none
package ostt_pkg;

	localparam int SLOTS_DEF       = 16;
	localparam int COUNT_WIDTH_DEF = 32;

	localparam int KIND_W       = 2;
	localparam int ID_W         = 16;
	localparam int TIMEOUT_W    = 32;
	localparam int WORD_W       = 32;
	localparam int RANGE_LO_W   = 16;
	localparam int RANGE_HI_W   = 17;
	localparam int SLOT_INDEX_W = 4;

	localparam logic [KIND_W-1:0] KIND_TICK  = 2'd0;
	localparam logic [KIND_W-1:0] KIND_RUN   = 2'd1;
	localparam logic [KIND_W-1:0] KIND_STOP  = 2'd2;
	localparam logic [KIND_W-1:0] KIND_CLEAR = 2'd3;

	localparam logic RES_REPLY  = 1'b0;
	localparam logic RES_EXPIRY = 1'b1;

	// Strobes from the controller to the datapath.
	typedef struct packed {
		logic capture;
		logic rd_en;
		logic proc;
		logic flush;
		logic reply;
	} dp_cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic [KIND_W-1:0] kind;
		logic              hit;
		logic              stall;
		logic              pend_v;
		logic              ofree;
	} dp_stat_t;

	typedef struct packed {
		logic                     result_kind;
		logic [SLOT_INDEX_W-1:0]  slot_index;
		logic                     found;
		logic [ID_W-1:0]          expired_id;
		logic signed [WORD_W-1:0] expired_a;
		logic signed [WORD_W-1:0] expired_b;
		logic                     last;
	} res_t;

endpackage
`default_nettype wire

// File: rtl/ostt_ifs.sv
// Valid/ready channel interfaces for commands and results of the timer table.
`timescale 1ns / 1ps
`default_nettype none
interface ostt_cmd_if;
	import ostt_pkg::*;

	logic                     valid;
	logic                     ready;
	logic [KIND_W-1:0]        kind;
	logic [ID_W-1:0]          timer_id;
	logic [TIMEOUT_W-1:0]     timeout;
	logic signed [WORD_W-1:0] param_a;
	logic signed [WORD_W-1:0] param_b;
	logic [RANGE_LO_W-1:0]    range_low;
	logic [RANGE_HI_W-1:0]    range_high;

	modport source (output valid, kind, timer_id, timeout, param_a, param_b, range_low,
		range_high, input ready);
	modport sink (input valid, kind, timer_id, timeout, param_a, param_b, range_low,
		range_high, output ready);
endinterface

interface ostt_rsp_if;
	import ostt_pkg::*;

	logic                     valid;
	logic                     ready;
	logic                     result_kind;
	logic [SLOT_INDEX_W-1:0]  slot_index;
	logic                     found;
	logic [ID_W-1:0]          expired_id;
	logic signed [WORD_W-1:0] expired_a;
	logic signed [WORD_W-1:0] expired_b;
	logic                     last;

	modport source (output valid, result_kind, slot_index, found, expired_id, expired_a,
		expired_b, last, input ready);
	modport sink (input valid, result_kind, slot_index, found, expired_id, expired_a,
		expired_b, last, output ready);
endinterface
`default_nettype wire

// File: rtl/ostt_ctrl.sv
// Controller: command sequencing and slot scan counters of the timer table.
`timescale 1ns / 1ps
`default_nettype none
module ostt_ctrl #(
	parameter int SLOTS = ostt_pkg::SLOTS_DEF
) (
	input  wire logic                                clk,
	input  wire logic                                arst_n,
	input  wire logic                                in_valid,
	output logic                                     in_ready,
	input  wire ostt_pkg::dp_stat_t                  st,
	output ostt_pkg::dp_cmd_t                        cmd,
	output logic [(SLOTS > 1 ? $clog2(SLOTS) : 1)-1:0] rd_idx,
	output logic [(SLOTS > 1 ? $clog2(SLOTS) : 1)-1:0] proc_idx
);
	import ostt_pkg::*;

	localparam int IDX_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;
	localparam int CNT_W = $clog2(SLOTS + 1);

	localparam logic [1:0] S_IDLE  = 2'd0;
	localparam logic [1:0] S_SCAN  = 2'd1;
	localparam logic [1:0] S_FLUSH = 2'd2;
	localparam logic [1:0] S_REPLY = 2'd3;

	logic [1:0]       state_q, state_d;
	logic [CNT_W-1:0] rd_cnt_q;
	logic [IDX_W-1:0] proc_idx_q;
	logic             proc_v_q;

	logic proc_ok, advance, done_reading;

	assign done_reading = (rd_cnt_q == CNT_W'(SLOTS));
	assign proc_ok      = (state_q == S_SCAN) && proc_v_q && !st.stall;
	assign advance      = (state_q == S_SCAN) && (!proc_v_q || proc_ok);
	assign in_ready     = (state_q == S_IDLE);
	assign rd_idx       = rd_cnt_q[IDX_W-1:0];
	assign proc_idx     = proc_idx_q;

	always_comb begin
		cmd         = '0;
		state_d     = state_q;
		cmd.capture = (state_q == S_IDLE) && in_valid;
		cmd.proc    = proc_ok;
		cmd.rd_en   = advance && !done_reading;
		case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					state_d = S_SCAN;
				end
			end
			S_SCAN: begin
				if (proc_ok && st.hit) begin
					state_d = S_REPLY;
				end else if (advance && done_reading) begin
					if (st.kind == KIND_TICK) begin
						state_d = S_FLUSH;
					end else if (st.kind inside {KIND_RUN, KIND_STOP}) begin
						state_d = S_REPLY;
					end else begin
						state_d = S_IDLE;
					end
				end
			end
			S_FLUSH: begin
				if (!st.pend_v) begin
					state_d = S_IDLE;
				end else if (st.ofree) begin
					cmd.flush = 1'b1;
					state_d   = S_IDLE;
				end
			end
			S_REPLY: begin
				if (st.ofree) begin
					cmd.reply = 1'b1;
					state_d   = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= S_IDLE;
			rd_cnt_q   <= '0;
			proc_idx_q <= '0;
			proc_v_q   <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.capture) begin
				rd_cnt_q <= '0;
				proc_v_q <= 1'b0;
			end else if (proc_ok && st.hit) begin
				proc_v_q <= 1'b0;
			end else if (advance) begin
				if (!done_reading) begin
					proc_idx_q <= rd_cnt_q[IDX_W-1:0];
					proc_v_q   <= 1'b1;
					rd_cnt_q   <= rd_cnt_q + CNT_W'(1);
				end else begin
					proc_v_q <= 1'b0;
				end
			end
		end
	end
endmodule
`default_nettype wire

// File: rtl/ostt_dp.sv
// Datapath: slot memories, compares, expiry buffer and result register.
`timescale 1ns / 1ps
`default_nettype none
module ostt_dp #(
	parameter int SLOTS       = ostt_pkg::SLOTS_DEF,
	parameter int COUNT_WIDTH = ostt_pkg::COUNT_WIDTH_DEF
) (
	input  wire logic                                     clk,
	input  wire logic                                     arst_n,
	input  wire logic [ostt_pkg::KIND_W-1:0]              in_kind,
	input  wire logic [ostt_pkg::ID_W-1:0]                in_timer_id,
	input  wire logic [ostt_pkg::TIMEOUT_W-1:0]           in_timeout,
	input  wire logic signed [ostt_pkg::WORD_W-1:0]       in_param_a,
	input  wire logic signed [ostt_pkg::WORD_W-1:0]       in_param_b,
	input  wire logic [ostt_pkg::RANGE_LO_W-1:0]          in_range_low,
	input  wire logic [ostt_pkg::RANGE_HI_W-1:0]          in_range_high,
	input  wire ostt_pkg::dp_cmd_t                        cmd,
	input  wire logic [(SLOTS > 1 ? $clog2(SLOTS) : 1)-1:0] rd_idx,
	input  wire logic [(SLOTS > 1 ? $clog2(SLOTS) : 1)-1:0] proc_idx,
	output ostt_pkg::dp_stat_t                            st,
	output logic                                          res_valid,
	input  wire logic                                     res_ready,
	output ostt_pkg::res_t                                res
);
	import ostt_pkg::*;

	localparam int IDX_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;

	// Latched command
	logic [KIND_W-1:0]      kind_q;
	logic [ID_W-1:0]        id_q;
	logic [COUNT_WIDTH-1:0] tmo_q;
	logic [WORD_W-1:0]      pa_q, pb_q;
	logic [RANGE_LO_W-1:0]  lo_q;
	logic [RANGE_HI_W-1:0]  hi_q;

	// Slot storage; active bit marks a nonzero id
	logic [SLOTS-1:0]       active_q;
	logic [ID_W-1:0]        id_mem  [SLOTS];
	logic [COUNT_WIDTH-1:0] cnt_mem [SLOTS];
	logic [WORD_W-1:0]      a_mem   [SLOTS];
	logic [WORD_W-1:0]      b_mem   [SLOTS];

	logic [ID_W-1:0]        id_rd_q;
	logic [COUNT_WIDTH-1:0] cnt_rd_q;
	logic [WORD_W-1:0]      a_rd_q, b_rd_q;

	// Held expiry, sent once the next one (or the end of the scan) is known
	logic                   pend_v_q;
	logic [IDX_W-1:0]       pend_idx_q;
	logic [ID_W-1:0]        pend_id_q;
	logic [WORD_W-1:0]      pend_a_q, pend_b_q;

	logic [IDX_W-1:0]       rep_idx_q;
	logic                   rep_found_q;

	logic                   out_v_q;
	res_t                   out_q;

	logic                   is_tick, is_run, is_stop, is_clear;
	logic                   act_p, expire, hit, in_range, ofree, push;
	logic [ID_W-1:0]        cur_id;
	logic [COUNT_WIDTH-1:0] dec;
	logic                   run_wr;
	logic [IDX_W-1:0]       wr_idx;

	assign is_tick  = (kind_q == KIND_TICK);
	assign is_run   = (kind_q == KIND_RUN);
	assign is_stop  = (kind_q == KIND_STOP);
	assign is_clear = (kind_q == KIND_CLEAR);

	assign act_p    = active_q[proc_idx];
	assign cur_id   = act_p ? id_rd_q : '0;
	assign dec      = cnt_rd_q - COUNT_WIDTH'(1);
	assign expire   = is_tick && act_p && (dec == '0);
	assign hit      = (is_run || is_stop) && (cur_id == id_q);
	assign in_range = (id_rd_q >= lo_q) && ({1'b0, id_rd_q} < hi_q);
	assign ofree    = !out_v_q || res_ready;
	assign push     = cmd.proc && expire && pend_v_q;
	assign run_wr   = cmd.reply && is_run && rep_found_q;
	assign wr_idx   = cmd.reply ? rep_idx_q : proc_idx;

	assign st.kind   = kind_q;
	assign st.hit    = hit;
	assign st.stall  = expire && pend_v_q && !ofree;
	assign st.pend_v = pend_v_q;
	assign st.ofree  = ofree;

	assign res_valid = out_v_q;
	assign res       = out_q;

	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			kind_q <= in_kind;
			id_q   <= in_timer_id;
			tmo_q  <= COUNT_WIDTH'(in_timeout);
			pa_q   <= in_param_a;
			pb_q   <= in_param_b;
			lo_q   <= in_range_low;
			hi_q   <= in_range_high;
		end
	end

	// Memory write port: run claim/re-arm at reply time, counter update on tick
	always_ff @(posedge clk) begin
		if (run_wr) begin
			id_mem[wr_idx] <= id_q;
			a_mem[wr_idx]  <= pa_q;
			b_mem[wr_idx]  <= pb_q;
		end
		if (run_wr) begin
			cnt_mem[wr_idx] <= tmo_q;
		end else if (cmd.proc && is_tick && act_p) begin
			cnt_mem[wr_idx] <= dec;
		end
	end

	// Memory read port
	always_ff @(posedge clk) begin
		if (cmd.rd_en) begin
			id_rd_q  <= id_mem[rd_idx];
			cnt_rd_q <= cnt_mem[rd_idx];
			a_rd_q   <= a_mem[rd_idx];
			b_rd_q   <= b_mem[rd_idx];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_q <= '0;
		end else begin
			if (cmd.proc && (expire || (is_clear && act_p && in_range))) begin
				active_q[proc_idx] <= 1'b0;
			end
			if (run_wr) begin
				active_q[rep_idx_q] <= (id_q != '0);
			end
			if (cmd.reply && is_stop && rep_found_q) begin
				active_q[rep_idx_q] <= 1'b0;
			end
		end
	end

	// Reply slot: first match wins and ends the scan; otherwise the last free seen
	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			rep_found_q <= 1'b0;
		end else if (cmd.proc && (hit || (is_run && cur_id == '0))) begin
			rep_idx_q   <= proc_idx;
			rep_found_q <= 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_v_q <= 1'b0;
		end else if (cmd.proc && expire) begin
			pend_v_q <= 1'b1;
		end else if (cmd.flush) begin
			pend_v_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.proc && expire) begin
			pend_idx_q <= proc_idx;
			pend_id_q  <= id_rd_q;
			pend_a_q   <= a_rd_q;
			pend_b_q   <= b_rd_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_v_q <= 1'b0;
		end else if (push || cmd.flush || cmd.reply) begin
			out_v_q <= 1'b1;
		end else if (res_ready) begin
			out_v_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (push || cmd.flush) begin
			out_q.result_kind <= RES_EXPIRY;
			out_q.slot_index  <= SLOT_INDEX_W'(pend_idx_q);
			out_q.found       <= 1'b1;
			out_q.expired_id  <= pend_id_q;
			out_q.expired_a   <= pend_a_q;
			out_q.expired_b   <= pend_b_q;
			out_q.last        <= cmd.flush;
		end else if (cmd.reply) begin
			out_q.result_kind <= RES_REPLY;
			out_q.slot_index  <= rep_found_q ? SLOT_INDEX_W'(rep_idx_q) : '0;
			out_q.found       <= rep_found_q;
			out_q.expired_id  <= '0;
			out_q.expired_a   <= '0;
			out_q.expired_b   <= '0;
			out_q.last        <= 1'b1;
		end
	end
endmodule
`default_nettype wire

// File: rtl/one_shot_timer_table_top.sv
// Top level of the one-shot timer table: controller, datapath and channel ports.
`timescale 1ns / 1ps
`default_nettype none
// One-shot timer table with SLOTS slots, each holding a 16-bit id (zero means
// free), a COUNT_WIDTH-bit down-counter and two 32-bit user words; reset frees
// every slot. Commands arrive as beats on cmd; results leave as beats on rsp.
// A tick decrements every active slot and sends one expiry beat per slot that
// reaches zero, in slot order, freeing it; the final expiry of a tick has last
// set, and a tick with no expiry sends nothing. A run re-arms the lowest slot
// holding the id, or else claims the highest free slot, and always answers
// with one reply beat (found clear when the table is full). A stop frees the
// lowest slot holding the id and answers with one reply beat. A clear-range
// frees every id in [range_low, range_high) and sends nothing. A timeout of
// zero fires after 2^COUNT_WIDTH ticks. The slot store is a memory with one
// read port, so every command walks the slots one per cycle, save while a
// tick's held expiry waits for room on rsp; a run or stop ends its scan at
// the first matching slot. The block takes one command at a time: cmd.ready
// is high only between commands, while the last result can still wait in
// the output register.
module one_shot_timer_table_top #(
	parameter int SLOTS       = ostt_pkg::SLOTS_DEF,
	parameter int COUNT_WIDTH = ostt_pkg::COUNT_WIDTH_DEF
) (
	input wire logic   clk,
	input wire logic   arst_n,
	ostt_cmd_if.sink   cmd,
	ostt_rsp_if.source rsp
);
	import ostt_pkg::*;

	localparam int IDX_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;

	dp_cmd_t          dp_cmd;
	dp_stat_t         dp_st;
	logic [IDX_W-1:0] rd_idx;
	logic [IDX_W-1:0] proc_idx;
	res_t             res;

	// Sequencing: accept, scan slots, then flush the held expiry (tick) or reply (run, stop).
	ostt_ctrl #(
		.SLOTS(SLOTS)
	) u_ctrl (
		.clk     (clk),
		.arst_n  (arst_n),
		.in_valid(cmd.valid),
		.in_ready(cmd.ready),
		.st      (dp_st),
		.cmd     (dp_cmd),
		.rd_idx  (rd_idx),
		.proc_idx(proc_idx)
	);

	// Slot memories, match/expiry logic and the result register.
	ostt_dp #(
		.SLOTS      (SLOTS),
		.COUNT_WIDTH(COUNT_WIDTH)
	) u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_kind      (cmd.kind),
		.in_timer_id  (cmd.timer_id),
		.in_timeout   (cmd.timeout),
		.in_param_a   (cmd.param_a),
		.in_param_b   (cmd.param_b),
		.in_range_low (cmd.range_low),
		.in_range_high(cmd.range_high),
		.cmd          (dp_cmd),
		.rd_idx       (rd_idx),
		.proc_idx     (proc_idx),
		.st           (dp_st),
		.res_valid    (rsp.valid),
		.res_ready    (rsp.ready),
		.res          (res)
	);

	// Drive the result beat fields.
	assign rsp.result_kind = res.result_kind;
	assign rsp.slot_index  = res.slot_index;
	assign rsp.found       = res.found;
	assign rsp.expired_id  = res.expired_id;
	assign rsp.expired_a   = res.expired_a;
	assign rsp.expired_b   = res.expired_b;
	assign rsp.last        = res.last;
endmodule
`default_nettype wire

// File: rtl/ostt_checker.sv
// Port-level checks of the timer table, bound to the top level.
`timescale 1ns / 1ps
`default_nettype none
module ostt_checker (
	input wire logic                                clk,
	input wire logic                                arst_n,
	input wire logic                                out_valid,
	input wire logic                                out_ready,
	input wire logic                                result_kind,
	input wire logic [ostt_pkg::SLOT_INDEX_W-1:0]   slot_index,
	input wire logic                                found,
	input wire logic [ostt_pkg::ID_W-1:0]           expired_id,
	input wire logic                                last
);
	import ostt_pkg::*;

	// Hold a stalled result beat.
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(slot_index) && $stable(expired_id)
			&& $stable(last))
	else $error("result beat changed while stalled");

	// A reply is always the only result of its command.
	a_reply_last: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && result_kind == RES_REPLY |-> last)
	else $error("reply without last");

	// An expiry always names a live timer.
	a_expiry: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && result_kind == RES_EXPIRY |-> found && expired_id != '0)
	else $error("expiry with zero id or not found");

	// A failed reply reports slot zero.
	a_fail: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !found |-> result_kind == RES_REPLY && slot_index == '0)
	else $error("failure result with nonzero slot");
endmodule

bind one_shot_timer_table_top ostt_checker u_ostt_checker (
	.clk        (clk),
	.arst_n     (arst_n),
	.out_valid  (rsp.valid),
	.out_ready  (rsp.ready),
	.result_kind(rsp.result_kind),
	.slot_index (rsp.slot_index),
	.found      (rsp.found),
	.expired_id (rsp.expired_id),
	.last       (rsp.last)
);
`default_nettype wire
